// File: src/irpd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the pulse-distance infrared transmitter
package irpd_pkg;

    // frame layout
    localparam int unsigned FRAME_BYTES = 6;
    localparam int unsigned FRAME_BITS  = FRAME_BYTES * 8;
    localparam int unsigned BITS_W      = 6;
    localparam logic [7:0]  ID_BYTE0    = 8'h02;
    localparam logic [7:0]  ID_BYTE1    = 8'h20;

    // transmit phases
    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_LEAD_MARK  = 3'd1;
    localparam logic [2:0] PH_LEAD_SPACE = 3'd2;
    localparam logic [2:0] PH_BIT_MARK   = 3'd3;
    localparam logic [2:0] PH_BIT_SPACE  = 3'd4;
    localparam logic [2:0] PH_TRAILER    = 3'd5;

    // register map
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_CARRIER_PERIOD = 3'd0;
    localparam logic [2:0] REG_LEAD_MARK      = 3'd1;
    localparam logic [2:0] REG_LEAD_SPACE     = 3'd2;
    localparam logic [2:0] REG_BIT_MARK       = 3'd3;
    localparam logic [2:0] REG_ZERO_SPACE     = 3'd4;
    localparam logic [2:0] REG_ONE_SPACE      = 3'd5;
    localparam logic [2:0] REG_TRAILER_MARK   = 3'd6;
    localparam logic [2:0] REG_DEVICE_PAIR    = 3'd7;

    // command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SEND = 1'b1;

    // input word
    typedef struct packed {
        logic       command;
        logic [7:0] button;
    } in_word_t;

    // result word
    typedef struct packed {
        logic ir_out;
        logic envelope;
        logic busy_res;
        logic accepted;
    } out_word_t;

    // classified queue entry
    typedef struct packed {
        logic       is_send;
        logic [7:0] button;
    } q_entry_t;

    // live configuration
    typedef struct packed {
        logic [7:0]  carrier_period;
        logic [15:0] lead_mark_ticks;
        logic [15:0] lead_space_ticks;
        logic [15:0] bit_mark_ticks;
        logic [15:0] zero_space_ticks;
        logic [15:0] one_space_ticks;
        logic [15:0] trailer_mark_ticks;
        logic [15:0] device_pair;
    } cfg_t;

endpackage

// File: src/ir_pulse_distance_transmitter_unit.sv
`timescale 1ns / 1ps
// top level of the pulse-distance infrared transmitter
//
// usage:
//   cmd channel (cmd_valid / cmd_stall / cmd_word) takes one word per cycle:
//   when not stalled: a tick word advances the transmitter by one time tick,
//   a send word with a button code starts a 48-bit frame if no frame is in progress.
//   res channel (res_valid / res_stall / res_word) returns exactly one word per
//   input word, in order: emitter level, mark envelope, busy and accepted flags.
//   the bus port holds carrier period, mark and space lengths and device bytes;
//   write it only while no words are in flight.
// timing:
//   an accepted word passes through the queue, then the result register;
//   one word per cycle sustained while res_stall stays low.
//   a two-word queue sits between input and engine, so a stalled result
//   register backs up into the queue and cmd_stall rises only when it is full.
// reset:
//   engine idle, queue and result register empty, registers at typical values.
module ir_pulse_distance_transmitter_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  irpd_pkg::in_word_t          cmd_word,
    output logic                        res_valid,
    input  logic                        res_stall,
    output irpd_pkg::out_word_t         res_word,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [irpd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    irpd_pkg::cfg_t     cfg;
    logic               q_valid;
    irpd_pkg::q_entry_t q_data;
    logic               q_pop;

    // configuration registers
    irpd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input queue
    irpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop)
    );

    // transmit engine
    irpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

endmodule

// File: src/irpd_cfg.sv
`timescale 1ns / 1ps
// configuration register file behind the bus port
module irpd_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [irpd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output irpd_pkg::cfg_t              cfg
);

    irpd_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.carrier_period     <= 8'd27;
            cfg_reg.lead_mark_ticks    <= 16'd3456;
            cfg_reg.lead_space_ticks   <= 16'd1728;
            cfg_reg.bit_mark_ticks     <= 16'd432;
            cfg_reg.zero_space_ticks   <= 16'd432;
            cfg_reg.one_space_ticks    <= 16'd1296;
            cfg_reg.trailer_mark_ticks <= 16'd432;
            cfg_reg.device_pair        <= 16'h0090;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                irpd_pkg::REG_CARRIER_PERIOD: cfg_reg.carrier_period     <= pwdata[7:0];
                irpd_pkg::REG_LEAD_MARK:      cfg_reg.lead_mark_ticks    <= pwdata[15:0];
                irpd_pkg::REG_LEAD_SPACE:     cfg_reg.lead_space_ticks   <= pwdata[15:0];
                irpd_pkg::REG_BIT_MARK:       cfg_reg.bit_mark_ticks     <= pwdata[15:0];
                irpd_pkg::REG_ZERO_SPACE:     cfg_reg.zero_space_ticks   <= pwdata[15:0];
                irpd_pkg::REG_ONE_SPACE:      cfg_reg.one_space_ticks    <= pwdata[15:0];
                irpd_pkg::REG_TRAILER_MARK:   cfg_reg.trailer_mark_ticks <= pwdata[15:0];
                default:                      cfg_reg.device_pair        <= pwdata[15:0];
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            irpd_pkg::REG_CARRIER_PERIOD: prdata = {24'd0, cfg_reg.carrier_period};
            irpd_pkg::REG_LEAD_MARK:      prdata = {16'd0, cfg_reg.lead_mark_ticks};
            irpd_pkg::REG_LEAD_SPACE:     prdata = {16'd0, cfg_reg.lead_space_ticks};
            irpd_pkg::REG_BIT_MARK:       prdata = {16'd0, cfg_reg.bit_mark_ticks};
            irpd_pkg::REG_ZERO_SPACE:     prdata = {16'd0, cfg_reg.zero_space_ticks};
            irpd_pkg::REG_ONE_SPACE:      prdata = {16'd0, cfg_reg.one_space_ticks};
            irpd_pkg::REG_TRAILER_MARK:   prdata = {16'd0, cfg_reg.trailer_mark_ticks};
            default:                      prdata = {16'd0, cfg_reg.device_pair};
        endcase
    end

endmodule

// File: src/irpd_front.sv
`timescale 1ns / 1ps
// input side: takes words, classifies them and queues them for the engine
module irpd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  irpd_pkg::in_word_t  cmd_word,
    output logic                q_valid,
    output irpd_pkg::q_entry_t  q_data,
    input  logic                q_pop
);

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    irpd_pkg::q_entry_t  queue_mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push;
    logic                pop;
    irpd_pkg::q_entry_t  entry;

    // classify the incoming word
    always_comb
    begin
        entry.is_send = (cmd_word.command == irpd_pkg::CMD_SEND);
        entry.button  = cmd_word.button;
    end

    assign cmd_stall = (count_reg == QCNT_W'(QDEPTH));
    assign push      = cmd_valid && !cmd_stall;
    assign q_valid   = (count_reg != '0);
    assign pop       = q_pop && q_valid;
    assign q_data    = queue_mem[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= entry;
        end
    end

endmodule

// File: src/irpd_back.sv
`timescale 1ns / 1ps
// transmit engine: frame builder, phase sequencer, carrier and result register
module irpd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  irpd_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  irpd_pkg::q_entry_t  q_data,
    output logic                q_pop,
    output logic                res_valid,
    input  logic                res_stall,
    output irpd_pkg::out_word_t res_word
);

    localparam logic [irpd_pkg::BITS_W-1:0] FRAME_BITS =
        irpd_pkg::BITS_W'(irpd_pkg::FRAME_BITS);

    logic [irpd_pkg::FRAME_BITS-1:0] frame_reg, frame_next;
    logic [irpd_pkg::BITS_W-1:0]     bits_left_reg, bits_left_next;
    logic [2:0]                      phase_reg, phase_next;
    logic [15:0]                     ticks_reg, ticks_next;
    logic [7:0]                      carrier_reg, carrier_next;
    logic                            cur_bit_reg, cur_bit_next;
    logic                            res_valid_reg, res_valid_next;
    irpd_pkg::out_word_t             res_word_reg, res_word_next;

    logic        fire;
    logic        active;
    logic        mark;
    logic [15:0] len;
    logic [15:0] ticks_inc;
    logic [7:0]  chk;

    assign fire      = q_valid && (!res_valid_reg || !res_stall);
    assign q_pop     = fire;
    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    assign active = (phase_reg >= irpd_pkg::PH_LEAD_MARK) &&
                    (phase_reg <= irpd_pkg::PH_TRAILER);
    assign mark   = (phase_reg == irpd_pkg::PH_LEAD_MARK) ||
                    (phase_reg == irpd_pkg::PH_BIT_MARK) ||
                    (phase_reg == irpd_pkg::PH_TRAILER);
    assign ticks_inc = ticks_reg + 16'd1;
    assign chk = cfg.device_pair[7:0] ^ cfg.device_pair[15:8] ^ q_data.button;

    // length of the current phase
    always_comb
    begin
        unique case (phase_reg)
            irpd_pkg::PH_LEAD_MARK:  len = cfg.lead_mark_ticks;
            irpd_pkg::PH_LEAD_SPACE: len = cfg.lead_space_ticks;
            irpd_pkg::PH_BIT_MARK:   len = cfg.bit_mark_ticks;
            irpd_pkg::PH_BIT_SPACE:  len = cur_bit_reg ? cfg.one_space_ticks
                                                       : cfg.zero_space_ticks;
            default:                 len = cfg.trailer_mark_ticks;
        endcase
    end

    // one word per firing: send request or one time tick
    always_comb
    begin
        frame_next     = frame_reg;
        bits_left_next = bits_left_reg;
        phase_next     = phase_reg;
        ticks_next     = ticks_reg;
        carrier_next   = carrier_reg;
        cur_bit_next   = cur_bit_reg;
        res_word_next  = '0;

        if (fire)
        begin
            if (q_data.is_send)
            begin
                res_word_next.busy_res = 1'b1;
                if (!active)
                begin
                    frame_next = {chk, q_data.button, cfg.device_pair[15:8],
                                  cfg.device_pair[7:0], irpd_pkg::ID_BYTE1,
                                  irpd_pkg::ID_BYTE0};
                    bits_left_next = FRAME_BITS;
                    cur_bit_next   = 1'b0;
                    phase_next     = irpd_pkg::PH_LEAD_MARK;
                    ticks_next     = '0;
                    carrier_next   = '0;
                    res_word_next.accepted = 1'b1;
                end
            end
            else if (active)
            begin
                res_word_next.busy_res = 1'b1;
                // carrier during marks
                if (mark)
                begin
                    res_word_next.envelope = 1'b1;
                    res_word_next.ir_out   = (carrier_reg <= (cfg.carrier_period >> 1));
                    carrier_next = (carrier_reg >= cfg.carrier_period) ? 8'd0
                                                                      : carrier_reg + 8'd1;
                end
                // phase advance
                ticks_next = ticks_inc;
                if (ticks_inc >= len)
                begin
                    ticks_next   = '0;
                    carrier_next = '0;
                    unique case (phase_reg)
                        irpd_pkg::PH_LEAD_MARK:
                        begin
                            phase_next = irpd_pkg::PH_LEAD_SPACE;
                        end
                        irpd_pkg::PH_BIT_MARK:
                        begin
                            phase_next = irpd_pkg::PH_BIT_SPACE;
                        end
                        irpd_pkg::PH_LEAD_SPACE, irpd_pkg::PH_BIT_SPACE:
                        begin
                            if ((phase_reg == irpd_pkg::PH_BIT_SPACE) && (bits_left_reg == '0))
                            begin
                                phase_next = irpd_pkg::PH_TRAILER;
                            end
                            else
                            begin
                                cur_bit_next   = frame_reg[0];
                                frame_next     = frame_reg >> 1;
                                bits_left_next = bits_left_reg - 1'b1;
                                phase_next     = irpd_pkg::PH_BIT_MARK;
                            end
                        end
                        default:
                        begin
                            phase_next = irpd_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
            else
            begin
                phase_next = irpd_pkg::PH_IDLE;
            end
        end
    end

    // result register handshake
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg     <= '0;
            bits_left_reg <= '0;
            phase_reg     <= irpd_pkg::PH_IDLE;
            ticks_reg     <= '0;
            carrier_reg   <= '0;
            cur_bit_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            frame_reg     <= frame_next;
            bits_left_reg <= bits_left_next;
            phase_reg     <= phase_next;
            ticks_reg     <= ticks_next;
            carrier_reg   <= carrier_next;
            cur_bit_reg   <= cur_bit_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_word_reg <= res_word_next;
        end
    end

`ifndef ASSERT_OFF
    // an accepted send always reports busy
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_word_reg.accepted |-> res_word_reg.busy_res)
        else $error("accepted send without busy");

    // carrier only inside a mark
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_word_reg.ir_out |-> res_word_reg.envelope)
        else $error("carrier outside mark");

    // an idle engine has no bits pending
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == irpd_pkg::PH_IDLE |-> bits_left_reg == '0)
        else $error("bits left while idle");

    // a send taken while idle starts the lead-in mark
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && q_data.is_send && !active |=> phase_reg == irpd_pkg::PH_LEAD_MARK)
        else $error("send did not start frame");
`endif

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the pulse-distance infrared transmitter unit
module tb_top;

    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned MAX_GAP     = 18;
    localparam int unsigned TAIL_CYCLES = 8;
    localparam int unsigned NUM_REGS    = 8;
    localparam int unsigned NUM_ROWS    = 22;

    // one directed word with an optional hand-typed result
    typedef struct packed {
        irpd_pkg::in_word_t  word;
        logic                typed;
        irpd_pkg::out_word_t want;
    } directed_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cmd_valid;
    logic                        cmd_stall;
    irpd_pkg::in_word_t          cmd_word;
    logic                        res_valid;
    logic                        res_stall;
    irpd_pkg::out_word_t         res_word;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [irpd_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    // transmitter image kept in step with accepted words
    irpd_pkg::cfg_t cfg_now;
    logic [47:0]    tx_shift;
    logic [5:0]     tx_bits_left;
    logic [2:0]     tx_phase;
    logic [15:0]    tx_ticks;
    logic [7:0]     tx_carrier;
    logic           tx_bit;

    irpd_pkg::out_word_t pending_levels [$];
    irpd_pkg::out_word_t rx_want;
    int unsigned         rx_hold = 0;
    int unsigned         mismatch_count = 0;
    int unsigned         cycle_count = 0;
    bit                  gaps_on = 1'b1;

    // tick idle, send, send while busy, start of the lead-in burst with its carrier
    directed_row_t directed_rows [NUM_ROWS] = '{
        '{'{irpd_pkg::CMD_TICK, 8'h00}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{irpd_pkg::CMD_TICK, 8'hFF}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{irpd_pkg::CMD_SEND, 8'hFF}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b1}},
        '{'{irpd_pkg::CMD_SEND, 8'h00}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0}},
        '{'{irpd_pkg::CMD_TICK, 8'h00}, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0}},
        '{'{irpd_pkg::CMD_TICK, 8'h00}, 1'b0, '0},
        '{'{irpd_pkg::CMD_TICK, 8'h00}, 1'b0, '0},
        '{'{irpd_pkg::CMD_TICK, 8'hFF}, 1'b0, '0},
        '{'{irpd_pkg::CMD_TICK, 8'h00}, 1'b0, '0},
        '{'{irpd_pkg::CMD_TICK, 8'h00}, 1'b0, '0},
        '{'{irpd_pkg::CMD_TICK, 8'h00}, 1'b0, '0},
        '{'{irpd_pkg::CMD_TICK, 8'h00}, 1'b0, '0},
        '{'{irpd_pkg::CMD_TICK, 8'h00}, 1'b0, '0},
        '{'{irpd_pkg::CMD_TICK, 8'h00}, 1'b0, '0},
        '{'{irpd_pkg::CMD_TICK, 8'h00}, 1'b0, '0},
        '{'{irpd_pkg::CMD_TICK, 8'h00}, 1'b0, '0},
        '{'{irpd_pkg::CMD_TICK, 8'h00}, 1'b0, '0},
        '{'{irpd_pkg::CMD_TICK, 8'h00}, 1'b0, '0},
        '{'{irpd_pkg::CMD_TICK, 8'h00}, 1'b0, '0},
        '{'{irpd_pkg::CMD_SEND, 8'h5A}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0}},
        '{'{irpd_pkg::CMD_TICK, 8'h00}, 1'b0, '0},
        '{'{irpd_pkg::CMD_TICK, 8'h00}, 1'b0, '0}
    };

    ir_pulse_distance_transmitter_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic got, input logic want);
        if (got !== want)
            report_mismatch($sformatf("%s got %b want %b", name, got, want));
    endtask

    function automatic void enter_phase(input logic [2:0] next_phase);
        tx_phase   = next_phase;
        tx_ticks   = '0;
        tx_carrier = '0;
    endfunction

    // shift out the next frame bit and start its mark
    function automatic void load_next_bit();
        tx_bit       = tx_shift[0];
        tx_shift     = tx_shift >> 1;
        tx_bits_left = tx_bits_left - 1'b1;
        enter_phase(irpd_pkg::PH_BIT_MARK);
    endfunction

    // emitter levels for one word, advancing the transmitter image
    function automatic irpd_pkg::out_word_t advance_transmitter(input irpd_pkg::in_word_t w);
        irpd_pkg::out_word_t lvl;
        logic                active;
        logic                mark;
        logic [15:0]         len;
        logic [7:0]          lo;
        logic [7:0]          hi;
        lvl    = '0;
        active = (tx_phase >= irpd_pkg::PH_LEAD_MARK) && (tx_phase <= irpd_pkg::PH_TRAILER);
        // send request: no time passes
        if (w.command == irpd_pkg::CMD_SEND)
        begin
            if (!active)
            begin
                lo           = cfg_now.device_pair[7:0];
                hi           = cfg_now.device_pair[15:8];
                tx_shift     = {lo ^ hi ^ w.button, w.button, hi, lo,
                                irpd_pkg::ID_BYTE1, irpd_pkg::ID_BYTE0};
                tx_bits_left = 6'(irpd_pkg::FRAME_BITS);
                tx_bit       = 1'b0;
                enter_phase(irpd_pkg::PH_LEAD_MARK);
                lvl.accepted = 1'b1;
            end
            lvl.busy_res = 1'b1;
            return lvl;
        end
        if (!active)
        begin
            tx_phase = irpd_pkg::PH_IDLE;
            return lvl;
        end
        mark = (tx_phase == irpd_pkg::PH_LEAD_MARK) || (tx_phase == irpd_pkg::PH_BIT_MARK)
            || (tx_phase == irpd_pkg::PH_TRAILER);
        case (tx_phase)
            irpd_pkg::PH_LEAD_MARK:  len = cfg_now.lead_mark_ticks;
            irpd_pkg::PH_LEAD_SPACE: len = cfg_now.lead_space_ticks;
            irpd_pkg::PH_BIT_MARK:   len = cfg_now.bit_mark_ticks;
            irpd_pkg::PH_BIT_SPACE:  len = tx_bit ? cfg_now.one_space_ticks
                                                  : cfg_now.zero_space_ticks;
            default:                 len = cfg_now.trailer_mark_ticks;
        endcase
        lvl.busy_res = 1'b1;
        // carrier runs 0..top, high while it is at most half of top
        if (mark)
        begin
            lvl.envelope = 1'b1;
            lvl.ir_out   = (tx_carrier <= (cfg_now.carrier_period >> 1));
            if (tx_carrier >= cfg_now.carrier_period)
                tx_carrier = '0;
            else
                tx_carrier = tx_carrier + 1'b1;
        end
        tx_ticks = tx_ticks + 1'b1;
        if (tx_ticks >= len)
        begin
            case (tx_phase)
                irpd_pkg::PH_LEAD_MARK:  enter_phase(irpd_pkg::PH_LEAD_SPACE);
                irpd_pkg::PH_LEAD_SPACE: load_next_bit();
                irpd_pkg::PH_BIT_MARK:   enter_phase(irpd_pkg::PH_BIT_SPACE);
                irpd_pkg::PH_BIT_SPACE:
                begin
                    if (tx_bits_left != 0)
                        load_next_bit();
                    else
                        enter_phase(irpd_pkg::PH_TRAILER);
                end
                default:                 enter_phase(irpd_pkg::PH_IDLE);
            endcase
        end
        return lvl;
    endfunction

    // mostly whole frames of ticks, some ignored sends while busy
    function automatic irpd_pkg::in_word_t pick_word();
        irpd_pkg::in_word_t w;
        w.button = 8'($urandom_range(0, 255));
        if (tx_phase == irpd_pkg::PH_IDLE)
            w.command = ($urandom_range(0, 9) < 8) ? irpd_pkg::CMD_SEND : irpd_pkg::CMD_TICK;
        else
            w.command = ($urandom_range(0, 19) == 0) ? irpd_pkg::CMD_SEND : irpd_pkg::CMD_TICK;
        return w;
    endfunction

    function automatic irpd_pkg::cfg_t random_timing(input int unsigned max_len);
        irpd_pkg::cfg_t c;
        c.carrier_period     = 8'($urandom_range(2, 9));
        c.lead_mark_ticks    = 16'($urandom_range(1, max_len));
        c.lead_space_ticks   = 16'($urandom_range(1, max_len));
        c.bit_mark_ticks     = 16'($urandom_range(1, max_len));
        c.zero_space_ticks   = 16'($urandom_range(1, max_len));
        c.one_space_ticks    = 16'($urandom_range(1, max_len));
        c.trailer_mark_ticks = 16'($urandom_range(1, max_len));
        c.device_pair        = 16'($urandom_range(0, 65535));
        return c;
    endfunction

    // one bus transfer: setup cycle then access cycle
    task automatic bus_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
    endtask

    // write every register, then read each back
    task automatic apply_config(input irpd_pkg::cfg_t c);
        logic [31:0] vals [NUM_REGS];
        logic [31:0] mask;
        logic [31:0] rd;
        vals[irpd_pkg::REG_CARRIER_PERIOD] = 32'(c.carrier_period);
        vals[irpd_pkg::REG_LEAD_MARK]      = 32'(c.lead_mark_ticks);
        vals[irpd_pkg::REG_LEAD_SPACE]     = 32'(c.lead_space_ticks);
        vals[irpd_pkg::REG_BIT_MARK]       = 32'(c.bit_mark_ticks);
        vals[irpd_pkg::REG_ZERO_SPACE]     = 32'(c.zero_space_ticks);
        vals[irpd_pkg::REG_ONE_SPACE]      = 32'(c.one_space_ticks);
        vals[irpd_pkg::REG_TRAILER_MARK]   = 32'(c.trailer_mark_ticks);
        vals[irpd_pkg::REG_DEVICE_PAIR]    = 32'(c.device_pair);
        for (int r = 0; r < NUM_REGS; r++)
            bus_access(1'b1, 3'(r), vals[r], rd);
        for (int r = 0; r < NUM_REGS; r++)
        begin
            bus_access(1'b0, 3'(r), 32'd0, rd);
            mask = (3'(r) == irpd_pkg::REG_CARRIER_PERIOD) ? 32'h0000_00FF : 32'h0000_FFFF;
            if ((rd & mask) !== vals[r])
                report_mismatch($sformatf("register %0d reads %h want %h", r, rd, vals[r]));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_now = c;
    endtask

    // hand one word to the block and queue its predicted levels
    task automatic push_word(input irpd_pkg::in_word_t w, input logic typed,
                             input irpd_pkg::out_word_t want);
        int unsigned         gap;
        irpd_pkg::out_word_t next_level;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        next_level = advance_transmitter(w);
        pending_levels.push_back(typed ? want : next_level);
    endtask

    // hold the sender until every pending word has come back
    task automatic drain_results();
        cmd_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
    endtask

    // result side: check each word, then stall a random number of cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (pending_levels.size() == 0)
                    report_mismatch("result word with nothing pending");
                else
                begin
                    rx_want = pending_levels.pop_front();
                    check_field("ir_out", res_word.ir_out, rx_want.ir_out);
                    check_field("envelope", res_word.envelope, rx_want.envelope);
                    check_field("busy_res", res_word.busy_res, rx_want.busy_res);
                    check_field("accepted", res_word.accepted, rx_want.accepted);
                end
                rx_hold = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (rx_hold != 0)
            begin
                res_stall <= 1'b1;
                rx_hold--;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // stimulus
    initial
    begin
        irpd_pkg::cfg_t     c;
        irpd_pkg::in_word_t w;
        int unsigned        quota;
        int unsigned        sent;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd_word  <= '0;
        res_stall <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        cfg_now = '{8'd27, 16'd3456, 16'd1728, 16'd432, 16'd432, 16'd1296, 16'd432, 16'h0090};
        tx_shift     = '0;
        tx_bits_left = '0;
        tx_phase     = irpd_pkg::PH_IDLE;
        tx_ticks     = '0;
        tx_carrier   = '0;
        tx_bit       = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words under the reset timing
        for (int i = 0; i < NUM_ROWS; i++)
            push_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

        // random words across several timings; the first change lands mid-frame
        for (int s = 0; s < 6; s++)
        begin
            drain_results();
            gaps_on = !(s == 1 || s == 4);
            quota   = 130;
            case (s)
                2: begin
                    // zero lengths and carrier top zero
                    c = '0;
                    quota = 60;
                end
                3: begin
                    c = random_timing(2);
                    c.carrier_period = 8'd1;
                    c.device_pair    = 16'hFFFF;
                    quota = 60;
                end
                4: begin
                    // longest lead-in burst with the widest carrier, cut short by the next timing
                    c = '0;
                    c.carrier_period  = 8'd255;
                    c.lead_mark_ticks = 16'hFFFF;
                    c.device_pair     = 16'($urandom_range(0, 65535));
                    quota = 280;
                end
                5: begin
                    c = random_timing(4);
                    c.carrier_period = 8'd2;
                    quota = 100;
                end
                default: c = random_timing(3);
            endcase
            apply_config(c);
            sent = 0;
            while (sent < quota || (s != 4 && tx_phase != irpd_pkg::PH_IDLE))
            begin
                w = pick_word();
                if (!(w.command == irpd_pkg::CMD_SEND && tx_phase != irpd_pkg::PH_IDLE))
                    sent++;
                push_word(w, 1'b0, '0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
src/irpd_pkg.sv
src/irpd_cfg.sv
src/irpd_front.sv
src/irpd_back.sv
src/ir_pulse_distance_transmitter_unit.sv
verif/tb_top.sv
